### src/srm_pkg.sv
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants for the step response metrics unit.
// ----------------------------------------------------------------------------
package srm_pkg;

  localparam int unsigned MAX_SAMPLES  = 65536;
  localparam int unsigned COUNT_W      = 17;
  localparam int unsigned SAMPLE_W     = 32;
  localparam int unsigned STAMP_W      = 32;
  localparam int unsigned TOL_W        = 16;
  localparam int unsigned TAIL_W       = 48;
  localparam int unsigned RATIO_W      = 31;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam int unsigned CFG_DATA_W   = 32;

  // shared divider: 49-bit dividend, 32-bit divisor, one quotient bit per cycle
  localparam int unsigned DIV_N_W      = 49;
  localparam int unsigned DIV_D_W      = 32;
  localparam int unsigned DIV_CNT_W    = 6;

  // floor(x/10) = (x * TAIL_RECIP) >> TAIL_SHIFT, exact for x < 2^20
  localparam int unsigned TAIL_RECIP   = 838861;
  localparam int unsigned TAIL_SHIFT   = 23;

  localparam logic [COUNT_W-1:0]    COUNT_RESET = COUNT_W'(1024);
  localparam logic [SAMPLE_W-1:0]   REF_RESET   = SAMPLE_W'(65536);
  localparam logic [TOL_W-1:0]      TOL_RESET   = TOL_W'(1311);
  localparam logic [COUNT_W-1:0]    COUNT_MIN   = COUNT_W'(2);
  localparam logic [COUNT_W-1:0]    COUNT_MAX   = COUNT_W'(MAX_SAMPLES);
  localparam logic [RATIO_W-1:0]    RATIO_SAT   = {RATIO_W{1'b1}};

  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_COUNT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REFERENCE_LEVEL = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE_BAND  = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BAND,
    S_UPD,
    S_OVR,
    S_OVR_W,
    S_AVG,
    S_AVG_W,
    S_FIN
  } srm_state_t;

  typedef struct packed {
    logic                       start;
    logic [DIV_N_W-1:0]         dividend;
    logic [DIV_D_W-1:0]         divisor;
  } srm_div_req_t;

  typedef struct packed {
    logic                       busy;
    logic                       done;
    logic [DIV_N_W-1:0]         quotient;
  } srm_div_rsp_t;

  typedef struct packed {
    logic                       upd;
    logic                       clear;
    logic                       last;
    logic                       ref_pos;
    logic                       oob;
    logic [COUNT_W-1:0]         tail_start;
    logic signed [SAMPLE_W-1:0] y;
    logic [STAMP_W-1:0]         t;
    logic signed [SAMPLE_W-1:0] ref_level;
  } srm_trk_ctl_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         sample_index;
    logic signed [TAIL_W-1:0]   tail_sum;
    logic signed [SAMPLE_W-1:0] peak_value;
    logic [STAMP_W-1:0]         peak_stamp;
    logic [STAMP_W-1:0]         low_stamp;
    logic                       low_found;
    logic [STAMP_W-1:0]         high_stamp;
    logic                       high_found;
    logic [STAMP_W-1:0]         settle_stamp;
  } srm_trk_state_t;

endpackage

### src/srm_if.sv
// ----------------------------------------------------------------------------
// srm_if
// Sample and result channels of the step response metrics unit.
// ----------------------------------------------------------------------------
interface srm_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [srm_pkg::SAMPLE_W-1:0] sample_value;
  logic [srm_pkg::STAMP_W-1:0]         sample_time;

  modport source (output valid, output sample_value, output sample_time, input ready);
  modport sink   (input valid, input sample_value, input sample_time, output ready);
endinterface

interface srm_out_if;
  logic                                valid;
  logic                                ready;
  logic [srm_pkg::STAMP_W-1:0]         rise_ticks;
  logic [srm_pkg::STAMP_W-1:0]         settle_ticks;
  logic [srm_pkg::STAMP_W-1:0]         peak_ticks;
  logic [srm_pkg::RATIO_W-1:0]         overshoot_ratio;
  logic signed [srm_pkg::SAMPLE_W-1:0] steady_value;
  logic [srm_pkg::RATIO_W-1:0]         steady_error;
  logic                                invalid_reference;

  modport source (output valid, output rise_ticks, output settle_ticks, output peak_ticks,
                  output overshoot_ratio, output steady_value, output steady_error,
                  output invalid_reference, input ready);
  modport sink   (input valid, input rise_ticks, input settle_ticks, input peak_ticks,
                  input overshoot_ratio, input steady_value, input steady_error,
                  input invalid_reference, output ready);
endinterface

### src/srm_div.sv
// ----------------------------------------------------------------------------
// srm_div
// Shared restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srm_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srm_pkg::srm_div_req_t req,
  output srm_pkg::srm_div_rsp_t rsp
);

  logic [srm_pkg::DIV_D_W-1:0]   rem_r;
  logic [srm_pkg::DIV_N_W-1:0]   quo_r;
  logic [srm_pkg::DIV_D_W-1:0]   dvs_r;
  logic [srm_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [srm_pkg::DIV_D_W:0]     trial;
  logic                          fits;
  logic [srm_pkg::DIV_D_W:0]     diff;

  always_comb begin
    trial = {rem_r, quo_r[srm_pkg::DIV_N_W-1]};
    fits  = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == srm_pkg::DIV_CNT_W'(srm_pkg::DIV_N_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[srm_pkg::DIV_D_W-1:0] : trial[srm_pkg::DIV_D_W-1:0];
      quo_r <= {quo_r[srm_pkg::DIV_N_W-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

### src/srm_track.sv
// ----------------------------------------------------------------------------
// srm_track
// Per-record running state: peak, crossings, settling stamp and tail sum.
// ----------------------------------------------------------------------------
module srm_track (
  input  logic                    clk,
  input  logic                    rst_n,
  input  srm_pkg::srm_trk_ctl_t   ctl,
  output srm_pkg::srm_trk_state_t st
);

  logic [srm_pkg::COUNT_W-1:0]         idx_r;
  logic signed [srm_pkg::TAIL_W-1:0]   tail_r;
  logic signed [srm_pkg::SAMPLE_W-1:0] peak_r;
  logic [srm_pkg::STAMP_W-1:0]         peak_t_r;
  logic [srm_pkg::STAMP_W-1:0]         low_t_r;
  logic                                low_f_r;
  logic [srm_pkg::STAMP_W-1:0]         high_t_r;
  logic                                high_f_r;
  logic [srm_pkg::STAMP_W-1:0]         settle_t_r;
  logic                                pend_r;

  logic signed [35:0] y36;
  logic signed [35:0] r36;
  logic signed [35:0] y10;
  logic signed [35:0] r9;
  logic               low_hit;
  logic               high_hit;
  logic               new_peak;
  logic               tail_en;

  always_comb begin
    y36      = 36'(ctl.y);
    r36      = 36'(ctl.ref_level);
    y10      = (y36 <<< 3) + (y36 <<< 1);
    r9       = (r36 <<< 3) + r36;
    low_hit  = y10 >= r36;
    high_hit = y10 >= r9;
    new_peak = (idx_r == '0) || (ctl.y > peak_r);
    tail_en  = idx_r >= ctl.tail_start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      idx_r      <= '0;
      tail_r     <= '0;
      peak_r     <= '0;
      peak_t_r   <= '0;
      low_t_r    <= '0;
      low_f_r    <= 1'b0;
      high_t_r   <= '0;
      high_f_r   <= 1'b0;
      settle_t_r <= '0;
      pend_r     <= 1'b0;
    end else if (ctl.upd) begin
      if (!ctl.last) idx_r <= idx_r + 1'b1;
      if (new_peak) begin
        peak_r   <= ctl.y;
        peak_t_r <= ctl.t;
      end
      // at most 2^16 samples of 2^31, no overflow in 48 bits
      if (tail_en) tail_r <= tail_r + srm_pkg::TAIL_W'(ctl.y);
      if (ctl.ref_pos && !low_f_r && low_hit) begin
        low_t_r <= ctl.t;
        low_f_r <= 1'b1;
      end
      if (ctl.ref_pos && !high_f_r && high_hit) begin
        high_t_r <= ctl.t;
        high_f_r <= 1'b1;
      end
      // the sample after an out-of-band one marks the settling time
      if (pend_r) begin
        settle_t_r <= ctl.t;
        pend_r     <= 1'b0;
      end
      if (ctl.ref_pos && ctl.oob) begin
        if (ctl.last) settle_t_r <= ctl.t;
        else          pend_r     <= 1'b1;
      end
    end
  end

  assign st.sample_index = idx_r;
  assign st.tail_sum     = tail_r;
  assign st.peak_value   = peak_r;
  assign st.peak_stamp   = peak_t_r;
  assign st.low_stamp    = low_t_r;
  assign st.low_found    = low_f_r;
  assign st.high_stamp   = high_t_r;
  assign st.high_found   = high_f_r;
  assign st.settle_stamp = settle_t_r;

endmodule

### src/step_response_metrics_unit.sv
// ----------------------------------------------------------------------------
// step_response_metrics_unit
// Step response metrics over records of timestamped Q16.16 samples.
// ----------------------------------------------------------------------------
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | sample_value, sample_time
//  out_ch  | out | valid/ready   | rise, settling, peak, overshoot, steady, error, flag
//  cfg_*   | in  | cfg_we only   | cfg_addr, cfg_wdata
//
//  A sample passes through the accept, band product and state update states.
//  The last sample of a record then runs two passes of the shared 49-step
//  divider (overshoot, then tail average), each started from its own sequencing
//  state, and the finish state loads the output register once it is free.
//  A pending result does not block the next sample unless a new result is due.
//  rst_n is synchronous; it clears the record state and loads register defaults.
// ----------------------------------------------------------------------------
module step_response_metrics_unit (
  input  logic                                 clk,
  input  logic                                 rst_n,
  srm_in_if.sink                               in_ch,
  srm_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [srm_pkg::CFG_ADDR_W-1:0]       cfg_addr,
  input  logic [srm_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  srm_pkg::srm_state_t state_r, state_nxt;

  logic [srm_pkg::COUNT_W-1:0]         count_r;
  logic signed [srm_pkg::SAMPLE_W-1:0] ref_r;
  logic [srm_pkg::TOL_W-1:0]           tol_r;

  logic signed [srm_pkg::SAMPLE_W-1:0] y_r;
  logic [srm_pkg::STAMP_W-1:0]         t_r;
  logic [srm_pkg::COUNT_W-1:0]         n_r;
  logic [srm_pkg::COUNT_W-1:0]         tail_start_r;
  logic                                last_r;
  logic [32:0]                         dev_r;
  logic [46:0]                         band_r;
  logic [srm_pkg::RATIO_W-1:0]         over_r;

  logic                                out_valid_r;
  logic [srm_pkg::STAMP_W-1:0]         rise_r;
  logic [srm_pkg::STAMP_W-1:0]         settle_r;
  logic [srm_pkg::STAMP_W-1:0]         ptime_r;
  logic [srm_pkg::RATIO_W-1:0]         ovr_out_r;
  logic signed [srm_pkg::SAMPLE_W-1:0] steady_r;
  logic [srm_pkg::RATIO_W-1:0]         err_r;
  logic                                flag_r;

  srm_pkg::srm_div_req_t   div_req;
  srm_pkg::srm_div_rsp_t   div_rsp;
  srm_pkg::srm_trk_ctl_t   trk_ctl;
  srm_pkg::srm_trk_state_t trk;

  logic                                in_ready;
  logic                                load_out;
  logic                                trk_upd;
  logic                                ref_pos;

  // effective count and tail start
  logic [srm_pkg::COUNT_W-1:0]         n_eff;
  logic [19:0]                         n9;
  logic [39:0]                         tail_prod;
  logic signed [32:0]                  dev_s;
  logic [32:0]                         dev_abs;

  // finishing arithmetic
  logic                                peak_above;
  logic [32:0]                         over_diff;
  logic [srm_pkg::COUNT_W-1:0]         tail_cnt;
  logic [srm_pkg::TAIL_W-1:0]          tail_mag;
  logic                                tail_neg;
  logic [srm_pkg::DIV_N_W-1:0]         q;
  logic signed [srm_pkg::SAMPLE_W-1:0] steady;
  logic signed [32:0]                  err_s;
  logic [32:0]                         err_abs;
  logic [srm_pkg::RATIO_W-1:0]         err_sat;
  logic [srm_pkg::STAMP_W-1:0]         rise;

  assign ref_pos = !ref_r[srm_pkg::SAMPLE_W-1] && (ref_r != '0);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= srm_pkg::COUNT_RESET;
      ref_r   <= srm_pkg::REF_RESET;
      tol_r   <= srm_pkg::TOL_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        srm_pkg::CFG_SAMPLE_COUNT:    count_r <= cfg_wdata[srm_pkg::COUNT_W-1:0];
        srm_pkg::CFG_REFERENCE_LEVEL: ref_r   <= cfg_wdata;
        srm_pkg::CFG_TOLERANCE_BAND:  tol_r   <= cfg_wdata[srm_pkg::TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer: next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      srm_pkg::S_IDLE:  if (in_ch.valid) state_nxt = srm_pkg::S_BAND;
      srm_pkg::S_BAND:  state_nxt = srm_pkg::S_UPD;
      srm_pkg::S_UPD:   state_nxt = last_r ? srm_pkg::S_OVR : srm_pkg::S_IDLE;
      srm_pkg::S_OVR:   state_nxt = srm_pkg::S_OVR_W;
      srm_pkg::S_OVR_W: if (div_rsp.done) state_nxt = srm_pkg::S_AVG;
      srm_pkg::S_AVG:   state_nxt = srm_pkg::S_AVG_W;
      srm_pkg::S_AVG_W: if (div_rsp.done) state_nxt = srm_pkg::S_FIN;
      srm_pkg::S_FIN:   if (!out_valid_r || out_ch.ready) state_nxt = srm_pkg::S_IDLE;
      default:          state_nxt = srm_pkg::S_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready         = 1'b0;
    load_out         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = {over_diff, 16'b0};
    div_req.divisor  = ref_r;
    trk_upd          = 1'b0;
    case (state_r)
      srm_pkg::S_IDLE: in_ready = 1'b1;
      srm_pkg::S_UPD:  trk_upd = 1'b1;
      srm_pkg::S_OVR:  div_req.start = 1'b1;
      srm_pkg::S_AVG: begin
        div_req.start    = 1'b1;
        div_req.dividend = srm_pkg::DIV_N_W'(tail_mag) + srm_pkg::DIV_N_W'(tail_cnt >> 1);
        div_req.divisor  = srm_pkg::DIV_D_W'(tail_cnt);
      end
      srm_pkg::S_FIN:  load_out = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= srm_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // per-sample front end
  always_comb begin
    n_eff = count_r;
    if (count_r < srm_pkg::COUNT_MIN) n_eff = srm_pkg::COUNT_MIN;
    if (count_r > srm_pkg::COUNT_MAX) n_eff = srm_pkg::COUNT_MAX;
    n9        = (20'(n_eff) << 3) + 20'(n_eff);
    tail_prod = 40'(n9) * 40'(srm_pkg::TAIL_RECIP);
    dev_s     = 33'(y_r) - 33'(ref_r);
    dev_abs   = dev_s[32] ? 33'(-dev_s) : 33'(dev_s);
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      y_r <= in_ch.sample_value;
      t_r <= in_ch.sample_time;
    end
    if (state_r == srm_pkg::S_BAND) begin
      n_r          <= n_eff;
      tail_start_r <= srm_pkg::COUNT_W'(tail_prod >> srm_pkg::TAIL_SHIFT);
      last_r       <= ({1'b0, trk.sample_index} + 18'd1) >= {1'b0, n_eff};
      dev_r        <= dev_abs;
      band_r       <= ref_r[30:0] * tol_r;
    end
  end

  // out of band: |y - ref| * 2^16 > ref * tol
  always_comb begin
    trk_ctl.upd        = trk_upd;
    trk_ctl.clear      = load_out;
    trk_ctl.last       = last_r;
    trk_ctl.ref_pos    = ref_pos;
    trk_ctl.oob        = {dev_r, 16'b0} > {2'b0, band_r};
    trk_ctl.tail_start = tail_start_r;
    trk_ctl.y          = y_r;
    trk_ctl.t          = t_r;
    trk_ctl.ref_level  = ref_r;
  end

  srm_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (trk_ctl),
    .st    (trk)
  );

  srm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // record finish
  always_comb begin
    peak_above = trk.peak_value > ref_r;
    over_diff  = 33'(trk.peak_value) - 33'(ref_r);
    tail_cnt   = n_r - tail_start_r;
    tail_neg   = trk.tail_sum[srm_pkg::TAIL_W-1];
    tail_mag   = tail_neg ? srm_pkg::TAIL_W'(-trk.tail_sum) : srm_pkg::TAIL_W'(trk.tail_sum);
    q          = div_rsp.quotient;
    if (tail_neg) begin
      if (q > srm_pkg::DIV_N_W'(33'h080000000)) steady = 32'sh80000000;
      else                                      steady = -$signed(q[31:0]);
    end else begin
      if (q > srm_pkg::DIV_N_W'(32'h7FFFFFFF))  steady = 32'sh7FFFFFFF;
      else                                      steady = $signed(q[31:0]);
    end
    err_s   = 33'(ref_r) - 33'(steady);
    err_abs = err_s[32] ? 33'(-err_s) : 33'(err_s);
    err_sat = (err_abs[32:31] != 2'b00) ? srm_pkg::RATIO_SAT : err_abs[30:0];
    rise    = (trk.low_found && trk.high_found && trk.high_stamp >= trk.low_stamp)
              ? trk.high_stamp - trk.low_stamp : '0;
  end

  always_ff @(posedge clk) begin
    if (state_r == srm_pkg::S_OVR_W && div_rsp.done) begin
      if (!peak_above)                 over_r <= '0;
      else if (q[48:31] != '0)         over_r <= srm_pkg::RATIO_SAT;
      else                             over_r <= q[30:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      flag_r    <= !ref_pos;
      rise_r    <= ref_pos ? rise : '0;
      settle_r  <= ref_pos ? trk.settle_stamp : '0;
      ptime_r   <= ref_pos ? trk.peak_stamp : '0;
      ovr_out_r <= ref_pos ? over_r : '0;
      steady_r  <= ref_pos ? steady : '0;
      err_r     <= ref_pos ? err_sat : '0;
    end
  end

  assign in_ch.ready              = in_ready;
  assign out_ch.valid             = out_valid_r;
  assign out_ch.rise_ticks        = rise_r;
  assign out_ch.settle_ticks      = settle_r;
  assign out_ch.peak_ticks        = ptime_r;
  assign out_ch.overshoot_ratio   = ovr_out_r;
  assign out_ch.steady_value      = steady_r;
  assign out_ch.steady_error      = err_r;
  assign out_ch.invalid_reference = flag_r;

  // checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == srm_pkg::S_FIN))
    else $error("result loaded outside finish state");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.invalid_reference) |->
      (out_ch.rise_ticks == '0 && out_ch.overshoot_ratio == '0 &&
       out_ch.steady_value == '0 && out_ch.steady_error == '0))
    else $error("metrics not cleared for invalid reference");

  a_upd_exit: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == srm_pkg::S_UPD |=> (state_r == srm_pkg::S_IDLE || state_r == srm_pkg::S_OVR))
    else $error("bad exit from sample update");

endmodule
